@@ design/gea_pkg.sv @@
// ----------------------------------------------------------------------------
// gea_pkg: shared types and constants for the gamepad event autorepeat block
//   Field widths, event and register codes, and the command and status
//   bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gea_pkg;

  // Number of pads served by default
  localparam int unsigned PAD_COUNT_DEFAULT = 4;

  // Field widths
  localparam int unsigned VBTN_COUNT = 24;
  localparam int unsigned VBTN_W     = 5;
  localparam int unsigned PAD_W      = 2;
  localparam int unsigned DIG_W      = 14;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned DELAY_W    = 31;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Event kinds as seen on the result channel
  typedef enum logic [KIND_W-1:0] {
    EVT_PRESS   = 2'd0,
    EVT_RELEASE = 2'd1,
    EVT_REPEAT  = 2'd2
  } evt_kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_LEFT   = 3'd0,
    CFG_TRIG_RIGHT  = 3'd1,
    CFG_DZ_LEFT     = 3'd2,
    CFG_DZ_RIGHT    = 3'd3,
    CFG_FIRST_DELAY = 3'd4,
    CFG_INTERVAL    = 3'd5
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input sample, start the button walk
    logic read_due;  // read the repeat timer of the current button
    logic use_due;   // judge the current button by its timer
    logic advance;   // commit the current button and step to the next
    logic flush;     // hand the held-back event out as the final one
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pad_ok;      // input pad lies within the pad count
    logic held;        // current button held on both samples
    logic last_btn;    // current button is the final one
    logic can_advance; // committing now loses nothing
    logic pend_valid;  // an event is held back
    logic out_free;    // output register can take an event this cycle
  } dp_sts_t;

endpackage

@@ design/gea_ctrl.sv @@
// ----------------------------------------------------------------------------
// gea_ctrl: sequencer for the gamepad event autorepeat block
//   Accepts a sample, walks the virtual buttons one by one, inserts a timer
//   read for each held button and closes with the final event.
// ----------------------------------------------------------------------------
module gea_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output gea_pkg::dp_cmd_t cmd_o,
  input  gea_pkg::dp_sts_t sts_i
);
  import gea_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // Decode commands and the next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.pad_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.held) begin
          cmd_o.read_due = 1'b1;
          state_d        = ST_CHECK;
        end else if (sts_i.can_advance) begin
          cmd_o.advance = 1'b1;
          if (sts_i.last_btn) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.use_due = 1'b1;
        if (sts_i.can_advance) begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.last_btn ? ST_FINISH : ST_SCAN;
        end
      end
      ST_FINISH: begin
        cmd_o.flush = 1'b1;
        if (!sts_i.pend_valid || sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

@@ design/gea_dpath.sv @@
// ----------------------------------------------------------------------------
// gea_dpath: datapath of the gamepad event autorepeat block
//   Configuration registers, virtual button forming, per-pad button history,
//   repeat timer memory, held-back event and output register.
// ----------------------------------------------------------------------------
module gea_dpath #(
  parameter int unsigned PAD_COUNT = gea_pkg::PAD_COUNT_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [gea_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gea_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample fields
  input  logic [gea_pkg::PAD_W-1:0]           pad_i,
  input  logic [gea_pkg::DIG_W-1:0]           digital_buttons_i,
  input  logic [gea_pkg::TRIG_W-1:0]          left_trigger_i,
  input  logic [gea_pkg::TRIG_W-1:0]          right_trigger_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   left_stick_x_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   left_stick_y_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   right_stick_x_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   right_stick_y_i,
  input  logic [gea_pkg::TICK_W-1:0]          now_ticks_i,
  // control
  input  gea_pkg::dp_cmd_t                    cmd_i,
  output gea_pkg::dp_sts_t                    sts_o,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gea_pkg::PAD_W-1:0]           event_pad_o,
  output logic [gea_pkg::VBTN_W-1:0]          virtual_button_o,
  output logic [gea_pkg::KIND_W-1:0]          event_kind_o,
  output logic                                last_event_o
);
  import gea_pkg::*;

  localparam int unsigned DEPTH  = PAD_COUNT * VBTN_COUNT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PIDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  // Configuration registers
  logic [TRIG_W-1:0]  thr_left_q, thr_right_q;
  logic [DZ_W-1:0]    dz_left_q, dz_right_q;
  logic [DELAY_W-1:0] first_delay_q, interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_left_q    <= '0;
      thr_right_q   <= '0;
      dz_left_q     <= '0;
      dz_right_q    <= '0;
      first_delay_q <= '0;
      interval_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TRIG_LEFT:   thr_left_q    <= cfg_data_i[TRIG_W-1:0];
        CFG_TRIG_RIGHT:  thr_right_q   <= cfg_data_i[TRIG_W-1:0];
        CFG_DZ_LEFT:     dz_left_q     <= cfg_data_i[DZ_W-1:0];
        CFG_DZ_RIGHT:    dz_right_q    <= cfg_data_i[DZ_W-1:0];
        CFG_FIRST_DELAY: first_delay_q <= cfg_data_i[DELAY_W-1:0];
        CFG_INTERVAL:    interval_q    <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Form the virtual buttons of the incoming sample
  logic signed [AXIS_W:0] lx, ly, rx, ry;
  logic signed [AXIS_W:0] dl_pos, dl_neg, dr_pos, dr_neg;
  logic [VBTN_COUNT-1:0]  new_btn;

  always_comb begin
    lx     = {left_stick_x_i[AXIS_W-1], left_stick_x_i};
    ly     = {left_stick_y_i[AXIS_W-1], left_stick_y_i};
    rx     = {right_stick_x_i[AXIS_W-1], right_stick_x_i};
    ry     = {right_stick_y_i[AXIS_W-1], right_stick_y_i};
    dl_pos = $signed({2'b00, dz_left_q});
    dr_pos = $signed({2'b00, dz_right_q});
    dl_neg = -dl_pos;
    dr_neg = -dr_pos;

    new_btn[9:0] = digital_buttons_i[9:0];
    new_btn[10]  = digital_buttons_i[10];
    new_btn[11]  = (left_trigger_i > thr_left_q);
    new_btn[12]  = digital_buttons_i[11];
    new_btn[13]  = digital_buttons_i[12];
    new_btn[14]  = (right_trigger_i > thr_right_q);
    new_btn[15]  = digital_buttons_i[13];
    new_btn[16]  = (ly > dl_pos);
    new_btn[17]  = (ly < dl_neg);
    new_btn[18]  = (lx < dl_neg);
    new_btn[19]  = (lx > dl_pos);
    new_btn[20]  = (ry > dr_pos);
    new_btn[21]  = (ry < dr_neg);
    new_btn[22]  = (rx < dr_neg);
    new_btn[23]  = (rx > dr_pos);
  end

  logic pad_ok;
  assign pad_ok = (32'(pad_i) < PAD_COUNT);

  // Per-pad button history; latch the sample on load
  logic [VBTN_COUNT-1:0] hist_q [PAD_COUNT];
  logic [VBTN_COUNT-1:0] cur_q, prv_q;
  logic [PAD_W-1:0]      pad_q;
  logic [TICK_W-1:0]     now_q;
  logic [ADDR_W-1:0]     base_q;
  logic [VBTN_W-1:0]     idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        hist_q[p] <= '0;
      end
    end else if (cmd_i.load) begin
      hist_q[PIDX_W'(pad_i)] <= new_btn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q  <= new_btn;
      prv_q  <= hist_q[PIDX_W'(pad_i)];
      pad_q  <= pad_i;
      now_q  <= now_ticks_i;
      base_q <= ADDR_W'(ADDR_W'(pad_i) * ADDR_W'(VBTN_COUNT));
    end
  end

  // Advance the button index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + VBTN_W'(1);
    end
  end

  logic cur_bit, prv_bit;
  assign cur_bit = cur_q[idx_q];
  assign prv_bit = prv_q[idx_q];

  // Repeat timer memory, one entry per pad and button
  logic [TICK_W-1:0] due_mem [DEPTH];
  logic [TICK_W-1:0] due_rd_q, due_wdata, due_diff;
  logic [ADDR_W-1:0] addr;
  logic              due_we, due_reached;

  assign addr = base_q + ADDR_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_due) begin
      due_rd_q <= due_mem[addr];
    end
    if (due_we) begin
      due_mem[addr] <= due_wdata;
    end
  end

  // Judge the current button
  logic      hit;
  evt_kind_e new_kind;

  assign due_diff    = now_q - due_rd_q;
  assign due_reached = !due_diff[TICK_W-1];
  assign hit         = cmd_i.use_due ? due_reached : (cur_bit ^ prv_bit);
  assign new_kind    = cmd_i.use_due ? EVT_REPEAT : (cur_bit ? EVT_PRESS : EVT_RELEASE);
  assign due_we      = cmd_i.advance && hit && (cmd_i.use_due || cur_bit);
  assign due_wdata   = now_q + (cmd_i.use_due ? {1'b0, interval_q} : {1'b0, first_delay_q});

  // Held-back event and output register
  logic              pend_valid_q;
  logic [VBTN_W-1:0] pend_btn_q;
  evt_kind_e         pend_kind_q;
  logic              out_valid_q, out_last_q;
  logic [PAD_W-1:0]  out_pad_q;
  logic [VBTN_W-1:0] out_btn_q;
  evt_kind_e         out_kind_q;
  logic              out_free, take_new, push_mid, push_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign take_new  = cmd_i.advance && hit;
  assign push_mid  = take_new && pend_valid_q;
  assign push_last = cmd_i.flush && pend_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (take_new) begin
        pend_valid_q <= 1'b1;
      end else if (push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_new) begin
      pend_btn_q  <= idx_q;
      pend_kind_q <= new_kind;
    end
    if (push_mid || push_last) begin
      out_pad_q  <= pad_q;
      out_btn_q  <= pend_btn_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_pad_o      = out_pad_q;
  assign virtual_button_o = out_btn_q;
  assign event_kind_o     = out_kind_q;
  assign last_event_o     = out_last_q;

  // Report status
  assign sts_o.pad_ok      = pad_ok;
  assign sts_o.held        = cur_bit & prv_bit;
  assign sts_o.last_btn    = (idx_q == VBTN_W'(VBTN_COUNT - 1));
  assign sts_o.can_advance = !hit || !pend_valid_q || out_free;
  assign sts_o.pend_valid  = pend_valid_q;
  assign sts_o.out_free    = out_free;

endmodule

@@ design/gamepad_event_autorepeat.sv @@
// ----------------------------------------------------------------------------
// gamepad_event_autorepeat: press, release and repeat events from pad samples
//   Forms 24 virtual buttons per sample, compares them with the pad's
//   previous buttons and emits events in button order with typematic repeat.
//
//   Channel   Handshake                 Payload
//   in        in_valid_i / in_stall_o   pad, buttons, triggers, sticks, ticks
//   out       out_valid_o / out_stall_i event_pad, virtual_button, kind, last
//   cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//   A sample is accepted, then the walk visits every virtual button in turn,
//   with an extra timer read from the single-port timer memory for each
//   button held on both this and the previous sample, and ends in a closing
//   step. Samples for pads beyond the pad count are taken and dropped. Reset
//   clears configuration and button history; timer entries are written on
//   press and on each repeat. A stalled output pauses the walk only when
//   a further event is found while the output register is still full, and
//   holds the closing cycle until the final event fits.
// ----------------------------------------------------------------------------
module gamepad_event_autorepeat #(
  parameter int unsigned PAD_COUNT = gea_pkg::PAD_COUNT_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gea_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gea_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // samples
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [gea_pkg::PAD_W-1:0]           pad_i,
  input  logic [gea_pkg::DIG_W-1:0]           digital_buttons_i,
  input  logic [gea_pkg::TRIG_W-1:0]          left_trigger_i,
  input  logic [gea_pkg::TRIG_W-1:0]          right_trigger_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   left_stick_x_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   left_stick_y_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   right_stick_x_i,
  input  logic signed [gea_pkg::AXIS_W-1:0]   right_stick_y_i,
  input  logic [gea_pkg::TICK_W-1:0]          now_ticks_i,
  // events
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gea_pkg::PAD_W-1:0]           event_pad_o,
  output logic [gea_pkg::VBTN_W-1:0]          virtual_button_o,
  output logic [gea_pkg::KIND_W-1:0]          event_kind_o,
  output logic                                last_event_o
);
  import gea_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  gea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gea_dpath #(
    .PAD_COUNT (PAD_COUNT)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pad_i             (pad_i),
    .digital_buttons_i (digital_buttons_i),
    .left_trigger_i    (left_trigger_i),
    .right_trigger_i   (right_trigger_i),
    .left_stick_x_i    (left_stick_x_i),
    .left_stick_y_i    (left_stick_y_i),
    .right_stick_x_i   (right_stick_x_i),
    .right_stick_y_i   (right_stick_y_i),
    .now_ticks_i       (now_ticks_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_pad_o       (event_pad_o),
    .virtual_button_o  (virtual_button_o),
    .event_kind_o      (event_kind_o),
    .last_event_o      (last_event_o)
  );

endmodule

@@ design/gea_checker.sv @@
// ----------------------------------------------------------------------------
// gea_checker: port-level checks for the gamepad event autorepeat block
//   Watches the top level's ports and flags broken event sequencing.
// ----------------------------------------------------------------------------
module gea_checker #(
  parameter int unsigned PAD_COUNT = gea_pkg::PAD_COUNT_DEFAULT
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [gea_pkg::PAD_W-1:0]           pad_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [gea_pkg::PAD_W-1:0]           event_pad_o,
  input logic [gea_pkg::VBTN_W-1:0]          virtual_button_o,
  input logic [gea_pkg::KIND_W-1:0]          event_kind_o,
  input logic                                last_event_o
);
  import gea_pkg::*;

  // A stalled event holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_pad_o)
      && $stable(virtual_button_o) && $stable(event_kind_o) && $stable(last_event_o))
    else $error("stalled event changed");

  // A sample for a served pad starts the button walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (32'(pad_i) < PAD_COUNT) |=> in_stall_o)
    else $error("accepted sample did not start the walk");

  // Once idle, only the final event of a sample can still wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> last_event_o)
    else $error("non-final event left over after the walk");

  // Events carry a real button and kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (virtual_button_o < VBTN_W'(VBTN_COUNT))
      && (event_kind_o != KIND_W'(3)))
    else $error("event with an invalid button or kind");

endmodule

bind gamepad_event_autorepeat gea_checker #(
  .PAD_COUNT (PAD_COUNT)
) u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .pad_i            (pad_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .event_pad_o      (event_pad_o),
  .virtual_button_o (virtual_button_o),
  .event_kind_o     (event_kind_o),
  .last_event_o     (last_event_o)
);

@@ tb/gamepad_event_autorepeat_tb.sv @@
// ----------------------------------------------------------------------------
// gamepad_event_autorepeat_tb: self-checking bench for the pad event block
//   Drives poll samples and register writes, predicts press, release and
//   repeat events per pad in button order, and checks every event transfer
//   field by field. Directed samples cover field extremes, thresholds,
//   deadzones and timer wrap; random samples mostly evolve each pad's state
//   with noise mixed in. The sample side idles and the event side stalls at random.
// ----------------------------------------------------------------------------
module gamepad_event_autorepeat_tb;
  import gea_pkg::*;

  localparam int unsigned PAD_COUNT       = PAD_COUNT_DEFAULT;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  // indexes past the register file; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef struct {
    logic [PAD_W-1:0]         pad;
    logic [DIG_W-1:0]         buttons;
    logic [TRIG_W-1:0]        lt;
    logic [TRIG_W-1:0]        rt;
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
    logic [TICK_W-1:0]        now;
  } pad_sample_t;

  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [VBTN_W-1:0] vbtn;
    evt_kind_e         kind;
    logic              last;
  } pad_event_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [PAD_W-1:0]         pad_i             = '0;
  logic [DIG_W-1:0]         digital_buttons_i = '0;
  logic [TRIG_W-1:0]        left_trigger_i    = '0;
  logic [TRIG_W-1:0]        right_trigger_i   = '0;
  logic signed [AXIS_W-1:0] left_stick_x_i    = '0;
  logic signed [AXIS_W-1:0] left_stick_y_i    = '0;
  logic signed [AXIS_W-1:0] right_stick_x_i   = '0;
  logic signed [AXIS_W-1:0] right_stick_y_i   = '0;
  logic [TICK_W-1:0]        now_ticks_i       = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [PAD_W-1:0]         event_pad_o;
  logic [VBTN_W-1:0]        virtual_button_o;
  logic [KIND_W-1:0]        event_kind_o;
  logic                     last_event_o;

  // predictor copy of the registers and per-pad state
  logic [TRIG_W-1:0]       thr_left, thr_right;
  logic [DZ_W-1:0]         dz_left, dz_right;
  logic [DELAY_W-1:0]      first_delay, interval;
  logic [VBTN_COUNT-1:0]   held_by_pad [PAD_COUNT];
  logic [TICK_W-1:0]       due_tick    [PAD_COUNT][VBTN_COUNT];

  pad_event_t  pending_events[$];
  pad_sample_t last_sample [PAD_COUNT];
  int          mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned burst_left     = 0;
  bit          sender_gaps_on = 1'b1;
  bit          hold_off_req   = 1'b0;

  gamepad_event_autorepeat #(
    .PAD_COUNT(PAD_COUNT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pad_i            (pad_i),
    .digital_buttons_i(digital_buttons_i),
    .left_trigger_i   (left_trigger_i),
    .right_trigger_i  (right_trigger_i),
    .left_stick_x_i   (left_stick_x_i),
    .left_stick_y_i   (left_stick_y_i),
    .right_stick_x_i  (right_stick_x_i),
    .right_stick_y_i  (right_stick_y_i),
    .now_ticks_i      (now_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_pad_o      (event_pad_o),
    .virtual_button_o (virtual_button_o),
    .event_kind_o     (event_kind_o),
    .last_event_o     (last_event_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the events of one accepted sample and advance the pad state
  function automatic void derive_pad_events(input pad_sample_t s);
    logic [VBTN_COUNT-1:0] now_held, was_held;
    logic [TICK_W-1:0]     since_due;
    bit                    fires   [VBTN_COUNT];
    evt_kind_e             kind_of [VBTN_COUNT];
    int                    lx, ly, rx, ry, dl, dr;
    int                    n_events, n_sent;
    pad_event_t            ev;
    lx = int'(s.lx);
    ly = int'(s.ly);
    rx = int'(s.rx);
    ry = int'(s.ry);
    dl = int'(dz_left);
    dr = int'(dz_right);
    now_held[9:0] = s.buttons[9:0];
    now_held[10]  = s.buttons[10];
    now_held[11]  = s.lt > thr_left;
    now_held[12]  = s.buttons[11];
    now_held[13]  = s.buttons[12];
    now_held[14]  = s.rt > thr_right;
    now_held[15]  = s.buttons[13];
    now_held[16]  = ly > dl;
    now_held[17]  = ly < -dl;
    now_held[18]  = lx < -dl;
    now_held[19]  = lx > dl;
    now_held[20]  = ry > dr;
    now_held[21]  = ry < -dr;
    now_held[22]  = rx < -dr;
    now_held[23]  = rx > dr;
    was_held = held_by_pad[s.pad];
    n_events = 0;
    for (int i = 0; i < VBTN_COUNT; i++) begin
      fires[i]   = 1'b0;
      kind_of[i] = EVT_PRESS;
      if (was_held[i] && now_held[i]) begin
        // wrap-safe due test: fire once now has reached the due tick
        since_due = s.now - due_tick[s.pad][i];
        if (!since_due[TICK_W-1]) begin
          fires[i]   = 1'b1;
          kind_of[i] = EVT_REPEAT;
          due_tick[s.pad][i] = s.now + {1'b0, interval};
        end
      end else if (was_held[i]) begin
        fires[i]   = 1'b1;
        kind_of[i] = EVT_RELEASE;
      end else if (now_held[i]) begin
        fires[i]   = 1'b1;
        kind_of[i] = EVT_PRESS;
        due_tick[s.pad][i] = s.now + {1'b0, first_delay};
      end
      if (fires[i]) n_events++;
    end
    n_sent = 0;
    for (int i = 0; i < VBTN_COUNT; i++) begin
      if (fires[i]) begin
        n_sent++;
        ev.pad  = s.pad;
        ev.vbtn = VBTN_W'(i);
        ev.kind = kind_of[i];
        ev.last = (n_sent == n_events);
        pending_events.push_back(ev);
      end
    end
    held_by_pad[s.pad] = now_held;
  endfunction

  function automatic pad_sample_t mk_sample(
    input logic [PAD_W-1:0] pad, input logic [DIG_W-1:0] buttons,
    input logic [TRIG_W-1:0] lt, input logic [TRIG_W-1:0] rt,
    input int lx, input int ly, input int rx, input int ry,
    input logic [TICK_W-1:0] now);
    pad_sample_t s;
    s.pad     = pad;
    s.buttons = buttons;
    s.lt      = lt;
    s.rt      = rt;
    s.lx      = AXIS_W'(lx);
    s.ly      = AXIS_W'(ly);
    s.rx      = AXIS_W'(rx);
    s.ry      = AXIS_W'(ry);
    s.now     = now;
    return s;
  endfunction

  // Bias axis readings towards the deadzone edges and the rails
  function automatic logic signed [AXIS_W-1:0] pick_axis(input logic [DZ_W-1:0] dz);
    int v;
    case ($urandom_range(0, 6))
      0:       v = int'(dz);
      1:       v = int'(dz) + 1;
      2:       v = -int'(dz);
      3:       v = -int'(dz) - 1;
      4:       v = 0;
      5:       v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = $urandom;
    endcase
    return AXIS_W'(v);
  endfunction

  function automatic logic [TRIG_W-1:0] pick_trigger(input logic [TRIG_W-1:0] thr);
    case ($urandom_range(0, 4))
      0:       return thr;
      1:       return thr + 1'b1;
      2:       return '0;
      3:       return '1;
      default: return TRIG_W'($urandom);
    endcase
  endfunction

  // Evolve a pad's last sample a little, or throw in a fully random one
  function automatic pad_sample_t make_sample(input logic [PAD_W-1:0] pad,
                                              input bit noisy,
                                              input int unsigned now_span);
    pad_sample_t s;
    if (noisy) begin
      s = mk_sample(pad, DIG_W'($urandom), TRIG_W'($urandom), TRIG_W'($urandom),
                    $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      s = last_sample[pad];
      s.buttons ^= DIG_W'($urandom & $urandom & $urandom);
      if ($urandom_range(0, 3) == 0) s.lt = pick_trigger(thr_left);
      if ($urandom_range(0, 3) == 0) s.rt = pick_trigger(thr_right);
      if ($urandom_range(0, 3) == 0) s.lx = pick_axis(dz_left);
      if ($urandom_range(0, 3) == 0) s.ly = pick_axis(dz_left);
      if ($urandom_range(0, 3) == 0) s.rx = pick_axis(dz_right);
      if ($urandom_range(0, 3) == 0) s.ry = pick_axis(dz_right);
      s.now = last_sample[pad].now + $urandom_range(0, now_span);
    end
    last_sample[pad] = s;
    return s;
  endfunction

  // Offer one sample, hold it until the transfer, then maybe idle a while
  task automatic send_sample(input pad_sample_t s);
    pad_i             <= s.pad;
    digital_buttons_i <= s.buttons;
    left_trigger_i    <= s.lt;
    right_trigger_i   <= s.rt;
    left_stick_x_i    <= s.lx;
    left_stick_y_i    <= s.ly;
    right_stick_x_i   <= s.rx;
    right_stick_y_i   <= s.ry;
    now_ticks_i       <= s.now;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    derive_pad_events(s);
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      end
      burst_left--;
    end
  endtask

  // Keep valid high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TRIG_LEFT:   thr_left    = value[TRIG_W-1:0];
      CFG_TRIG_RIGHT:  thr_right   = value[TRIG_W-1:0];
      CFG_DZ_LEFT:     dz_left     = value[DZ_W-1:0];
      CFG_DZ_RIGHT:    dz_right    = value[DZ_W-1:0];
      CFG_FIRST_DELAY: first_delay = value[DELAY_W-1:0];
      CFG_INTERVAL:    interval    = value[DELAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(input logic [CFG_DATA_W-1:0] trig_l, trig_r,
                                 input logic [CFG_DATA_W-1:0] dzone_l, dzone_r,
                                 input logic [CFG_DATA_W-1:0] delay, period);
    write_reg(CFG_TRIG_LEFT, trig_l);
    write_reg(CFG_TRIG_RIGHT, trig_r);
    write_reg(CFG_DZ_LEFT, dzone_l);
    write_reg(CFG_DZ_RIGHT, dzone_r);
    write_reg(CFG_FIRST_DELAY, delay);
    write_reg(CFG_INTERVAL, period);
    write_reg(CFG_IDX_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_IDX_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, wait for every pending event, then let the block go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int n_items, input int unsigned now_span,
                                  input int unsigned noise_pct);
    for (int k = 0; k < n_items; k++)
      send_sample(make_sample(PAD_W'($urandom_range(0, PAD_COUNT - 1)),
                              $urandom_range(0, 99) < noise_pct, now_span));
  endtask

  // Registers at reset value: any trigger or axis off zero counts as pressed
  task automatic test_reset_values();
    send_sample(mk_sample(0, '0, 1, 0, 1, -1, 0, 0, 32'd10));
    send_sample(mk_sample(0, '0, 0, 1, 0, 0, -1, 1, 32'd10));
    send_sample(mk_sample(1, '0, 0, 0, 0, 0, 0, 0, 32'd0));
    settle();
  endtask

  // Short delay, zero interval, masked threshold, timer due across the wrap
  task automatic test_short_delay();
    program_setting(31'h5A5A_5A64, 31'd255, 31'd0, 31'h7FFF_FFFF, 31'd5, 31'd0);
    send_sample(mk_sample(0, '0, 0, 0, 0, 0, 0, 0, 32'd0));
    send_sample(mk_sample(0, '1, 255, 255, 32767, -32768, -32768, 32767, 32'd1));
    send_sample(mk_sample(0, '1, 255, 255, 32767, -32768, -32768, 32767, 32'd3));
    send_sample(mk_sample(0, '1, 255, 255, 32767, -32768, -32768, 32767, 32'd6));
    send_sample(mk_sample(0, '1, 255, 255, 32767, -32768, -32768, 32767, 32'd6));
    send_sample(mk_sample(0, '0, 100, 0, -32768, 32767, 32767, -32768, 32'd7));
    send_sample(mk_sample(1, '1, 101, 255, 1, -1, -32767, 0, 32'hFFFF_FFFE));
    send_sample(mk_sample(1, '1, 101, 255, 1, -1, -32767, 0, 32'hFFFF_FFFF));
    send_sample(mk_sample(1, '1, 101, 255, 1, -1, -32767, 0, 32'd3));
    send_sample(mk_sample(2, 14'h2A55, 101, 0, 0, 1, 0, 0, 32'h7FFF_FFFF));
    send_sample(mk_sample(3, '0, 0, 0, 0, 0, 0, 0, 32'd0));
    send_sample(mk_sample(0, '0, 0, 0, 0, 0, 0, 0, 32'd8));
    settle();
  endtask

  // Longest delay and interval, zero thresholds, widest left deadzone
  task automatic test_long_delay();
    program_setting(31'd0, 31'd0, 31'h7FFF, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_sample(mk_sample(2, '1, 0, 0, 0, 0, 0, 0, 32'd0));
    send_sample(mk_sample(2, '1, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFE));
    send_sample(mk_sample(2, '1, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send_sample(mk_sample(2, '1, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
    send_sample(mk_sample(2, '1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFE));
    send_sample(mk_sample(3, '0, 1, 1, -32768, 32767, 1, -1, 32'd5));
    settle();
  endtask

  // Moderate settings, with a pause for all events halfway through
  task automatic test_random_mixed();
    program_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom_range(0, 20000)),
                    CFG_DATA_W'($urandom_range(0, 20000)),
                    CFG_DATA_W'($urandom_range(0, 30)),
                    CFG_DATA_W'($urandom_range(0, 10)));
    run_random_phase(25, 15, 10);
    settle();
    run_random_phase(25, 15, 10);
    settle();
  endtask

  task automatic test_zero_interval();
    program_setting(31'd255, 31'd0, 31'd0, 31'h7FFF, 31'd0, 31'd0);
    run_random_phase(30, 5, 10);
    settle();
  endtask

  // Large delays and big time steps, starting close to the tick wrap
  task automatic test_timer_wrap();
    program_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    for (int p = 0; p < PAD_COUNT; p++)
      last_sample[p].now = 32'hFFFF_FF00 + $urandom_range(0, 255);
    run_random_phase(40, 32'h0FFF_FFFF, 40);
    settle();
  endtask

  // Hold the event side off while samples keep coming back to back
  task automatic test_output_holdoff();
    program_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom_range(0, 8000)),
                    CFG_DATA_W'($urandom_range(0, 8000)),
                    CFG_DATA_W'($urandom_range(0, 20)),
                    CFG_DATA_W'($urandom_range(0, 8)));
    sender_gaps_on = 1'b0;
    hold_off_req   = 1'b1;
    run_random_phase(20, 10, 50);
    sender_gaps_on = 1'b1;
    settle();
  endtask

  task automatic test_random_registers();
    program_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom_range(0, 40)),
                    CFG_DATA_W'($urandom_range(0, 40)));
    run_random_phase(30, 30, 15);
    settle();
  endtask

  // Check each event transfer against the oldest prediction
  always @(posedge clk_i) begin : event_checker
    pad_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("event with none pending: pad %0d button %0d kind %0d last %0d",
               event_pad_o, virtual_button_o, event_kind_o, last_event_o);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_pad_o !== want.pad) begin
          $error("event_pad: expected %0d, got %0d", want.pad, event_pad_o);
          mismatch_count++;
        end
        if (virtual_button_o !== want.vbtn) begin
          $error("virtual_button: expected %0d, got %0d", want.vbtn, virtual_button_o);
          mismatch_count++;
        end
        if (event_kind_o !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind_o);
          mismatch_count++;
        end
        if (last_event_o !== want.last) begin
          $error("last_event: expected %0d, got %0d", want.last, last_event_o);
          mismatch_count++;
        end
      end
    end
  end

  // Event-side stall: random runs of light, heavy or no stall, plus hold-offs
  initial begin : stall_pattern
    int unsigned run_left;
    int unsigned mode;
    run_left = 0;
    mode     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 2);
        run_left = $urandom_range(5, 60);
      end
      run_left--;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Give up when no transfer happens on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    thr_left    = '0;
    thr_right   = '0;
    dz_left     = '0;
    dz_right    = '0;
    first_delay = '0;
    interval    = '0;
    for (int p = 0; p < PAD_COUNT; p++) begin
      held_by_pad[p] = '0;
      last_sample[p] = mk_sample(PAD_W'(p), '0, 0, 0, 0, 0, 0, 0, $urandom);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_short_delay();
    test_long_delay();
    test_random_mixed();
    test_zero_interval();
    test_timer_wrap();
    test_output_holdoff();
    test_random_registers();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/gea_pkg.sv
design/gea_ctrl.sv
design/gea_dpath.sv
design/gamepad_event_autorepeat.sv
design/gea_checker.sv
tb/gamepad_event_autorepeat_tb.sv
